/* hw/rtl/sfd_pkg.sv */
`timescale 1ns / 1ps

package sfd_pkg;

    // Quotient magnitude stays below 2**QBITS when the guard does not fire
    localparam int QBITS = 30;
    localparam int GUARD_SHIFT = 14;
    localparam int FRAC_BITS = 16;

    localparam logic [31:0] SAT_NEG = 32'h8000_0000;
    localparam logic [31:0] SAT_POS = 32'h7fff_ffff;

    typedef struct packed {
        logic signed [31:0] dividend;
        logic signed [31:0] divisor;
    } t_in;

    typedef struct packed {
        logic signed [31:0] quotient;
        logic               saturated;
    } t_out;

    // Data handed from one cell to the next
    typedef struct packed {
        logic              valid;
        logic              neg;
        logic              sat;
        logic [31:0]       divisor_mag;
        logic [31:0]       rem;
        logic [QBITS-1:0]  num;   // dividend bits still to bring down, msb first
        logic [QBITS-1:0]  quo;
    } t_cell;

endpackage

/* hw/rtl/saturating_fixed_divide_16_16.sv */
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// input     start & !busy             i_in  (dividend, divisor)
// result    o_done, one-cycle strobe  o_out (quotient, saturated)
//
// A new item may be started every cycle while busy is low; its result passes through the
// magnitude/guard stage, 30 division cells and the output stage.
// busy is high only during reset and the cycle after it.
// Synchronous active-low reset clears the valid bits down the row.
// The receiver cannot stall; results are never held.
module saturating_fixed_divide_16_16 (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  sfd_pkg::t_in   i_in,
    output logic           o_done,
    output sfd_pkg::t_out  o_out
);

    logic           r_ready;
    logic           accept;
    sfd_pkg::t_cell chain [sfd_pkg::QBITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign busy   = !r_ready;
    assign accept = start && r_ready;

    sfd_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_in    (i_in),
        .o_cell  (chain[0])
    );

    for (genvar g = 0; g < sfd_pkg::QBITS; g++) begin : g_cell
        sfd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (chain[g]),
            .o_cell  (chain[g+1])
        );
    end

    sfd_fin u_fin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (chain[sfd_pkg::QBITS]),
        .o_done  (o_done),
        .o_out   (o_out)
    );

endmodule

/* hw/rtl/sfd_prep.sv */
`timescale 1ns / 1ps

// Magnitudes, sign and overflow guard; seeds the partial remainder.
module sfd_prep (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sfd_pkg::t_in       i_in,
    output sfd_pkg::t_cell     o_cell
);

    logic [31:0] ua;
    logic [31:0] ub;
    sfd_pkg::t_cell n_cell;
    sfd_pkg::t_cell r_cell;

    always_comb begin
        ua = i_in.dividend[31] ? (32'd0 - i_in.dividend) : i_in.dividend;
        ub = i_in.divisor[31]  ? (32'd0 - i_in.divisor)  : i_in.divisor;

        n_cell.valid       = i_valid;
        n_cell.neg         = i_in.dividend[31] ^ i_in.divisor[31];
        n_cell.sat         = ({14'd0, ua[31:sfd_pkg::GUARD_SHIFT]} >= ub);
        n_cell.divisor_mag = ub;
        // (ua << 16) split: top 18 bits seed the remainder, low 30 bits follow
        n_cell.rem         = {14'd0, ua[31:sfd_pkg::GUARD_SHIFT]};
        n_cell.num         = {ua[sfd_pkg::GUARD_SHIFT-1:0], {sfd_pkg::FRAC_BITS{1'b0}}};
        n_cell.quo         = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell.valid <= n_cell.valid;
        end
        r_cell.neg         <= n_cell.neg;
        r_cell.sat         <= n_cell.sat;
        r_cell.divisor_mag <= n_cell.divisor_mag;
        r_cell.rem         <= n_cell.rem;
        r_cell.num         <= n_cell.num;
        r_cell.quo         <= n_cell.quo;
    end

    assign o_cell = r_cell;

endmodule

/* hw/rtl/sfd_cell.sv */
`timescale 1ns / 1ps

// One restoring step: bring down a bit, trial subtract, shift in a quotient bit.
module sfd_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sfd_pkg::t_cell     i_cell,
    output sfd_pkg::t_cell     o_cell
);

    logic [32:0] rem_sh;
    logic [32:0] diff;
    logic        ge;
    sfd_pkg::t_cell n_cell;
    sfd_pkg::t_cell r_cell;

    always_comb begin
        rem_sh = {i_cell.rem, i_cell.num[sfd_pkg::QBITS-1]};
        diff   = rem_sh - {1'b0, i_cell.divisor_mag};
        ge     = (rem_sh >= {1'b0, i_cell.divisor_mag});

        n_cell             = i_cell;
        // when the guard does not fire, the remainder stays below the divisor, so 32 bits hold it
        n_cell.rem         = ge ? diff[31:0] : rem_sh[31:0];
        n_cell.num         = {i_cell.num[sfd_pkg::QBITS-2:0], 1'b0};
        n_cell.quo         = {i_cell.quo[sfd_pkg::QBITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell.valid <= n_cell.valid;
        end
        r_cell.neg         <= n_cell.neg;
        r_cell.sat         <= n_cell.sat;
        r_cell.divisor_mag <= n_cell.divisor_mag;
        r_cell.rem         <= n_cell.rem;
        r_cell.num         <= n_cell.num;
        r_cell.quo         <= n_cell.quo;
    end

    assign o_cell = r_cell;

endmodule

/* hw/rtl/sfd_fin.sv */
`timescale 1ns / 1ps

// Sign restore and saturation select, registered onto the result port.
module sfd_fin (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sfd_pkg::t_cell     i_cell,
    output logic               o_done,
    output sfd_pkg::t_out      o_out
);

    logic [31:0]   mag;
    sfd_pkg::t_out n_out;
    sfd_pkg::t_out r_out;
    logic          r_done;

    always_comb begin
        mag = {{(32-sfd_pkg::QBITS){1'b0}}, i_cell.quo};
        if (i_cell.sat) begin
            n_out.quotient  = i_cell.neg ? sfd_pkg::SAT_NEG : sfd_pkg::SAT_POS;
            n_out.saturated = 1'b1;
        end else begin
            n_out.quotient  = i_cell.neg ? (32'd0 - mag) : mag;
            n_out.saturated = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cell.valid;
        end
        r_out <= n_out;
    end

    assign o_done = r_done;
    assign o_out  = r_out;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_ITEMS = 1950;
    localparam int CALM_TAIL = 200;     // last stretch with no idling at all
    localparam int DRAIN_AT = 700;
    localparam int LATENCY = 32;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic signed [31:0] MOST_NEG = sfd_pkg::SAT_NEG;
    localparam logic signed [31:0] MOST_POS = sfd_pkg::SAT_POS;

    class t_divide_scoreboard;
        sfd_pkg::t_out expected_quotients[$];
        int   mismatches;
        int   checked;
        int   saturations;

        function sfd_pkg::t_out predict_quotient(sfd_pkg::t_in op);
            logic [31:0] mag_a;
            logic [31:0] mag_b;
            logic [31:0] m;
            logic [63:0] wide;
            logic        neg;
            sfd_pkg::t_out r;
            // unsigned magnitudes: the most negative value maps to 0x80000000
            mag_a = op.dividend[31] ? (32'd0 - op.dividend) : op.dividend;
            mag_b = op.divisor[31] ? (32'd0 - op.divisor) : op.divisor;
            neg = op.dividend[31] ^ op.divisor[31];
            if ((mag_a >> sfd_pkg::GUARD_SHIFT) >= mag_b) begin
                r.quotient = neg ? sfd_pkg::SAT_NEG : sfd_pkg::SAT_POS;
                r.saturated = 1'b1;
            end else begin
                wide = {16'd0, mag_a, 16'd0} / {32'd0, mag_b};
                m = wide[31:0];
                r.quotient = neg ? (32'd0 - m) : m;
                r.saturated = 1'b0;
            end
            return r;
        endfunction

        function void note_operands(sfd_pkg::t_in op);
            expected_quotients.push_back(predict_quotient(op));
        endfunction

        task report(string what);
            if (mismatches < 20) $display("tb: mismatch: %s", what);
            mismatches++;
        endtask

        task check_quotient(sfd_pkg::t_out got);
            sfd_pkg::t_out want;
            if (expected_quotients.size() == 0) begin
                report($sformatf("result with nothing pending: q=%h sat=%b",
                                 got.quotient, got.saturated));
                return;
            end
            want = expected_quotients.pop_front();
            checked++;
            if (want.saturated) saturations++;
            if (got.quotient !== want.quotient)
                report($sformatf("item %0d quotient %h, wanted %h",
                                 checked, got.quotient, want.quotient));
            if (got.saturated !== want.saturated)
                report($sformatf("item %0d saturated %b, wanted %b",
                                 checked, got.saturated, want.saturated));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic o_done;
    sfd_pkg::t_in  i_in;
    sfd_pkg::t_out o_out;

    t_divide_scoreboard board;
    int cycle_count = 0;

    saturating_fixed_divide_16_16 DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_in   (i_in),
        .o_done (o_done),
        .o_out  (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Outputs and handshake are read at the edge, before this edge's updates land
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: timed out after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end else begin
            if (i_rst_n && start && !busy) board.note_operands(i_in);
            if (i_rst_n && o_done) board.check_quotient(o_out);
        end
    end

    // Holds the item until the block takes it; returns at the accepting edge
    task send_item(sfd_pkg::t_in op);
        i_in <= op;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task send_pair(logic signed [31:0] a, logic signed [31:0] b);
        sfd_pkg::t_in op;
        op.dividend = a;
        op.divisor = b;
        send_item(op);
    endtask

    task pause(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (board.expected_quotients.size() != 0);
    endtask

    // Random width and sign, so small and large magnitudes both turn up
    function logic signed [31:0] random_operand();
        logic [31:0] v;
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = 32'd0 - v;
        return v;
    endfunction

    function logic signed [31:0] special_operand();
        case ($urandom_range(0, 6))
            0: return 32'sd0;
            1: return 32'sd1;
            2: return -32'sd1;
            3: return MOST_NEG;
            4: return MOST_POS;
            5: return 32'sh0001_0000;
            default: return -32'sh0001_0000;
        endcase
    endfunction

    function sfd_pkg::t_in make_item();
        sfd_pkg::t_in op;
        logic [31:0]  mb;
        logic [31:0]  ma;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                op.dividend = $urandom;
                op.divisor = $urandom;
            end
            3, 4, 5: begin
                op.dividend = random_operand();
                op.divisor = random_operand();
            end
            6, 7: begin
                // straddle the saturation guard: |a| close to |b| << 14
                mb = $urandom_range(1, 32'h1_ffff);
                ma = (mb << sfd_pkg::GUARD_SHIFT) + $urandom_range(0, 4) - 2;
                op.dividend = $urandom_range(0, 1) ? (32'd0 - ma) : ma;
                op.divisor = $urandom_range(0, 1) ? (32'd0 - mb) : mb;
            end
            8: begin
                op.dividend = $urandom_range(0, 1) ? special_operand() : random_operand();
                op.divisor = $urandom_range(0, 1) ? special_operand() : random_operand();
            end
            default: begin
                op.dividend = random_operand();
                op.divisor = $urandom_range(0, 1) ? 32'sd0 : (32'($urandom_range(0, 7)) - 3);
            end
        endcase
        return op;
    endfunction

    initial begin
        board = new();
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_in <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero divisor, zero over zero, sign of a zero quotient
        send_pair(0, 0);
        send_pair(0, 1);
        send_pair(0, -1);
        send_pair(1, 0);
        send_pair(-1, 0);
        // most negative and most positive operands
        send_pair(MOST_NEG, MOST_NEG);
        send_pair(MOST_NEG, MOST_POS);
        send_pair(MOST_POS, MOST_NEG);
        send_pair(MOST_NEG, -1);
        send_pair(MOST_POS, 1);
        send_pair(MOST_POS, MOST_POS);
        send_pair(MOST_POS, -MOST_POS);
        // guard boundary, both sides of it
        send_pair(16383, 1);
        send_pair(16384, 1);
        send_pair(-16384, 1);
        send_pair(-16383, 1);
        send_pair(MOST_NEG, 32'sh0002_0000);
        send_pair(MOST_NEG, 32'sh0002_0001);
        send_pair(MOST_NEG, -32'sh0002_0001);
        // ordinary fractions and truncation toward zero
        send_pair(32'sh0001_0000, 32'sh0003_0000);
        send_pair(-(7 <<< 16), 2 <<< 16);
        send_pair(-1, MOST_POS);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == DRAIN_AT) drain_results();
            if (n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 5) == 0)
                pause($urandom_range(1, 10));
            send_item(make_item());
        end
        drain_results();
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("tb: %0d divisions checked (%0d saturated): directed edge cases, then",
                 board.checked, board.saturations);
        $display("tb: random full-range, narrow, near-guard and zero-divisor operands");
        if (board.mismatches == 0 && board.expected_quotients.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* saturating_fixed_divide_16_16.f */
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_prep.sv
hw/rtl/sfd_cell.sv
hw/rtl/sfd_fin.sv
hw/rtl/saturating_fixed_divide_16_16.sv
bench/tb.sv
